FILE: design/cce_pkg.sv
// Shared types and constants of the Coulomb counter with EMA current filter.
package cce_pkg;

	// Datapath widths.
	localparam int F_W     = 34;            // filter value, 0.1 mA with 16 fraction bits
	localparam int CHG_W   = 50;            // signed charge step, filter times elapsed time
	localparam int MAG_W   = 48;            // magnitude of the charge step
	localparam int EM_W    = 54;            // magnitude of the energy step
	localparam int DLT_W   = EM_W + 1;      // widest signed step added to a total
	localparam int LOAD_W  = 23;            // load voltage, 10 uV
	localparam int LMAG_W  = 22;            // magnitude of the load voltage
	localparam int MUL_W   = 72;            // product register of the shift-add unit
	localparam int MB_W    = LMAG_W;        // widest multiplier operand
	localparam int CNT_W   = $clog2(MB_W + 1);
	localparam int IN_W    = 64;
	localparam int OUT_W   = 296;

	// Number of multiplier bits scanned for each product.
	localparam logic [CNT_W-1:0] ALPHA_BITS = CNT_W'(16);
	localparam logic [CNT_W-1:0] EL_BITS    = CNT_W'(16);
	localparam logic [CNT_W-1:0] LOAD_BITS  = CNT_W'(MB_W);

	localparam logic [21:0] LOAD_SCALE = 22'd100;     // mV to 10 uV
	localparam logic [15:0] ROUND_HALF = 16'h8000;    // half of 2^16

	// Register indexes on the configuration channel.
	localparam logic [1:0] REG_DEADBAND  = 2'd0;
	localparam logic [1:0] REG_EMA_ALPHA = 2'd1;
	localparam logic [1:0] REG_IDLE_BAND = 2'd2;

	// Power state codes.
	localparam logic [1:0] PS_IDLE      = 2'd0;
	localparam logic [1:0] PS_CHARGE    = 2'd1;
	localparam logic [1:0] PS_DISCHARGE = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EMA_GO,
		S_EMA_WAIT,
		S_EMA_UPD,
		S_CHG_GO,
		S_CHG_WAIT,
		S_CHG_ACC,
		S_NRG_GO,
		S_NRG_WAIT,
		S_NRG_ACC,
		S_PUB
	} cce_state_t;

	// Which product the shared multiplier forms.
	typedef enum logic [1:0] {
		MOP_EMA,
		MOP_CHG,
		MOP_NRG
	} cce_mop_t;

	typedef struct packed {
		logic in_valid;
		logic mul_done;
		logic out_busy;
	} cce_status_t;

	typedef struct packed {
		logic     in_ready;
		logic     load_in;
		logic     mul_start;
		cce_mop_t mul_sel;
		logic     ema_upd;
		logic     chg_acc;
		logic     nrg_acc;
		logic     publish;
	} cce_ctrl_t;

endpackage

FILE: design/cce_mul.sv
// Shared shift-add multiplier: one multiplier bit and one add per cycle.
module cce_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [cce_pkg::MUL_W-1:0]         mcand,
	input  logic [cce_pkg::MB_W-1:0]          mplier,
	input  logic [cce_pkg::CNT_W-1:0]         nbits,
	input  logic [15:0]                       bias,
	output logic [cce_pkg::MUL_W-1:0]         product,
	output logic                              done
);

	logic                          busy_q;
	logic                          done_q;
	logic [cce_pkg::CNT_W-1:0]     cnt_q;
	logic [cce_pkg::MUL_W-1:0]     acc_q;
	logic [cce_pkg::MUL_W-1:0]     mcand_q;
	logic [cce_pkg::MB_W-1:0]      mplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == cce_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The multiplicand arrives sign extended, so the sum of its shifted copies is the
	// two's complement product for an unsigned multiplier.
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= {{(cce_pkg::MUL_W-16){1'b0}}, bias};
			mcand_q  <= mcand;
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[cce_pkg::MUL_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[cce_pkg::MB_W-1:1]};
		end
	end

	assign product = acc_q;
	assign done    = done_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("multiplier did not begin after start");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("multiplier done without a finished run");

endmodule

FILE: design/cce_fsm.sv
// Sequencer that steps one sample through the shared multiplier and the totals.
module cce_fsm (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cce_pkg::cce_status_t st,
	output cce_pkg::cce_ctrl_t   ctrl
);

	cce_pkg::cce_state_t state_q;
	cce_pkg::cce_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cce_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			cce_pkg::S_IDLE:     if (st.in_valid) state_d = cce_pkg::S_EMA_GO;
			cce_pkg::S_EMA_GO:   state_d = cce_pkg::S_EMA_WAIT;
			cce_pkg::S_EMA_WAIT: if (st.mul_done) state_d = cce_pkg::S_EMA_UPD;
			cce_pkg::S_EMA_UPD:  state_d = cce_pkg::S_CHG_GO;
			cce_pkg::S_CHG_GO:   state_d = cce_pkg::S_CHG_WAIT;
			cce_pkg::S_CHG_WAIT: if (st.mul_done) state_d = cce_pkg::S_CHG_ACC;
			cce_pkg::S_CHG_ACC:  state_d = cce_pkg::S_NRG_GO;
			cce_pkg::S_NRG_GO:   state_d = cce_pkg::S_NRG_WAIT;
			cce_pkg::S_NRG_WAIT: if (st.mul_done) state_d = cce_pkg::S_NRG_ACC;
			cce_pkg::S_NRG_ACC:  state_d = cce_pkg::S_PUB;
			cce_pkg::S_PUB:      if (!st.out_busy) state_d = cce_pkg::S_IDLE;
			default:             state_d = cce_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.mul_sel   = cce_pkg::MOP_EMA;
		case (state_q)
			cce_pkg::S_IDLE: begin
				ctrl.in_ready = 1'b1;
				ctrl.load_in  = st.in_valid;
			end
			cce_pkg::S_EMA_GO: begin
				ctrl.mul_start = 1'b1;
				ctrl.mul_sel   = cce_pkg::MOP_EMA;
			end
			cce_pkg::S_EMA_UPD: ctrl.ema_upd = 1'b1;
			cce_pkg::S_CHG_GO: begin
				ctrl.mul_start = 1'b1;
				ctrl.mul_sel   = cce_pkg::MOP_CHG;
			end
			cce_pkg::S_CHG_ACC: ctrl.chg_acc = 1'b1;
			cce_pkg::S_NRG_GO: begin
				ctrl.mul_start = 1'b1;
				ctrl.mul_sel   = cce_pkg::MOP_NRG;
			end
			cce_pkg::S_NRG_ACC: ctrl.nrg_acc = 1'b1;
			cce_pkg::S_PUB:     ctrl.publish = !st.out_busy;
			default:            ctrl = '0;
		endcase
	end

endmodule

FILE: design/coulomb_counter_ema.sv
// Top level of the Coulomb counter with EMA current filter and saturating totals.
// Each power-monitor sample on the s_ stream (elapsed ms, current, shunt and bus voltage)
// has its current zeroed inside the deadband, passes an EMA primed by the first sample,
// and is integrated into net charge, discharge and charge totals and net energy, all
// saturating (net values at signed ACC_WIDTH bits, the other two at ACC_WIDTH-1 bits);
// one result per sample leaves on the m_ stream. The result is presented in the same
// cycle in which s_tready rises again, so no new sample is accepted until the previous
// one is published. A single shift-add multiplier scans one multiplier bit per cycle for
// three products in turn: the filter weight (16 bits), the elapsed time (16 bits) and
// the load voltage (22 bits). s_tready is high only between samples.
// Results sit in an output register, so the next sample is taken while a result waits;
// a finished sample holds until that register is free. Registers on the cfg channel
// (0 deadband, 1 ema_alpha, 2 idle_band) are written whenever cfg_valid is high and
// should change only while idle.
module coulomb_counter_ema #(
	parameter int ACC_WIDTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// elapsed_ms[15:0], current_sample[31:16], shunt_voltage[47:32], bus_voltage[62:48]
	input  logic [cce_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// filtered_current[15:0], load_voltage[38:16], net_charge[102:39],
	// out_charge[165:103], in_charge[228:166], net_energy[292:229], power_state[294:293]
	output logic [cce_pkg::OUT_W-1:0]  m_tdata,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [15:0]                cfg_data
);

	localparam int SUM_W = ((ACC_WIDTH > cce_pkg::DLT_W) ? ACC_WIDTH : cce_pkg::DLT_W) + 1;
	localparam logic signed [SUM_W-1:0] SAT_MAX =
		{{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

	cce_pkg::cce_status_t st;
	cce_pkg::cce_ctrl_t   ctrl;

	// Configuration.
	logic [14:0] deadband_q;
	logic [15:0] alpha_q;
	logic [14:0] idle_band_q;

	// Sample and filter state.
	logic signed [15:0]                  cur_q;
	logic [15:0]                         el_q;
	logic signed [cce_pkg::LOAD_W-1:0]   load_q;
	logic [cce_pkg::LMAG_W-1:0]          load_mag_q;
	logic                                load_neg_q;
	logic signed [cce_pkg::F_W-1:0]      f_q;
	logic                                primed_q;
	logic [cce_pkg::MAG_W-1:0]           chg_mag_q;

	// Totals.
	logic signed [ACC_WIDTH-1:0] net_q;
	logic [ACC_WIDTH-2:0]        out_q;
	logic [ACC_WIDTH-2:0]        in_q;
	logic signed [ACC_WIDTH-1:0] nrg_q;

	// Output register.
	logic                                out_valid_q;
	logic signed [15:0]                  fc_oq;
	logic signed [cce_pkg::LOAD_W-1:0]   load_oq;
	logic signed [ACC_WIDTH-1:0]         net_oq;
	logic [ACC_WIDTH-2:0]                out_oq;
	logic [ACC_WIDTH-2:0]                in_oq;
	logic signed [ACC_WIDTH-1:0]         nrg_oq;
	logic [1:0]                          ps_oq;

	// Input decode.
	logic signed [15:0]                  in_cur;
	logic [16:0]                         in_cur_ext;
	logic [16:0]                         in_cur_mag;
	logic signed [15:0]                  in_cur_kept;
	logic [21:0]                         in_bus_scaled;
	logic signed [cce_pkg::LOAD_W-1:0]   in_load;
	logic [cce_pkg::LOAD_W-1:0]          in_load_neg;

	// Multiplier operands.
	logic [cce_pkg::MUL_W-1:0]           mul_mcand;
	logic [cce_pkg::MB_W-1:0]            mul_mplier;
	logic [cce_pkg::CNT_W-1:0]           mul_nbits;
	logic [15:0]                         mul_bias;
	logic [cce_pkg::MUL_W-1:0]           mul_prod;
	logic                                mul_done;
	logic [cce_pkg::F_W:0]               ema_diff;

	// Accumulation.
	logic                                f_neg;
	logic [cce_pkg::CHG_W-1:0]           chg;
	logic [cce_pkg::CHG_W-1:0]           chg_abs;
	logic [cce_pkg::MAG_W-1:0]           chg_mag;
	logic signed [SUM_W-1:0]             net_sum;
	logic [SUM_W-1:0]                    dir_base;
	logic [SUM_W-1:0]                    dir_sum;
	logic [ACC_WIDTH-2:0]                dir_next;
	logic [cce_pkg::EM_W-1:0]            em;
	logic [cce_pkg::DLT_W-1:0]           em_delta;
	logic signed [SUM_W-1:0]             nrg_sum;

	// Result formatting.
	logic signed [cce_pkg::F_W-1:0]      f_rnd;
	logic signed [cce_pkg::F_W-17:0]     fc_full;
	logic signed [15:0]                  fc;
	logic [cce_pkg::F_W-1:0]             f_mag;
	logic [1:0]                          ps;

	assign st.in_valid = s_tvalid;
	assign st.mul_done = mul_done;
	assign st.out_busy = out_valid_q && !m_tready;

	cce_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.st     (st),
		.ctrl   (ctrl)
	);

	cce_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (ctrl.mul_start),
		.mcand   (mul_mcand),
		.mplier  (mul_mplier),
		.nbits   (mul_nbits),
		.bias    (mul_bias),
		.product (mul_prod),
		.done    (mul_done)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = ctrl.in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q  <= 15'd30;
			alpha_q     <= 16'd9830;
			idle_band_q <= 15'd10;
		end else if (cfg_valid) begin
			case (cfg_index)
				cce_pkg::REG_DEADBAND:  deadband_q  <= cfg_data[14:0];
				cce_pkg::REG_EMA_ALPHA: alpha_q     <= cfg_data;
				cce_pkg::REG_IDLE_BAND: idle_band_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Input decode: deadband and load voltage.
	always_comb begin
		in_cur        = $signed(s_tdata[31:16]);
		in_cur_ext    = {in_cur[15], in_cur};
		in_cur_mag    = in_cur[15] ? (17'd0 - in_cur_ext) : in_cur_ext;
		in_cur_kept   = (in_cur_mag < {2'b00, deadband_q}) ? 16'sd0 : in_cur;
		in_bus_scaled = {7'd0, s_tdata[62:48]} * cce_pkg::LOAD_SCALE;
		in_load       = $signed({1'b0, in_bus_scaled}
		                + {{(cce_pkg::LOAD_W-16){s_tdata[47]}}, s_tdata[47:32]});
		in_load_neg   = {cce_pkg::LOAD_W{1'b0}} - in_load;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		ema_diff = {{3{cur_q[15]}}, cur_q, 16'h0000} - {f_q[cce_pkg::F_W-1], f_q};
		case (ctrl.mul_sel)
			cce_pkg::MOP_EMA: begin
				mul_mcand  = {{(cce_pkg::MUL_W-cce_pkg::F_W-1){ema_diff[cce_pkg::F_W]}},
				              ema_diff};
				mul_mplier = {{(cce_pkg::MB_W-16){1'b0}}, alpha_q};
				mul_nbits  = cce_pkg::ALPHA_BITS;
				mul_bias   = cce_pkg::ROUND_HALF;
			end
			cce_pkg::MOP_CHG: begin
				mul_mcand  = {{(cce_pkg::MUL_W-cce_pkg::F_W){f_q[cce_pkg::F_W-1]}}, f_q};
				mul_mplier = {{(cce_pkg::MB_W-16){1'b0}}, el_q};
				mul_nbits  = cce_pkg::EL_BITS;
				mul_bias   = 16'h0000;
			end
			cce_pkg::MOP_NRG: begin
				mul_mcand  = {{(cce_pkg::MUL_W-cce_pkg::MAG_W){1'b0}}, chg_mag_q};
				mul_mplier = load_mag_q;
				mul_nbits  = cce_pkg::LOAD_BITS;
				mul_bias   = cce_pkg::ROUND_HALF;
			end
			default: begin
				mul_mcand  = '0;
				mul_mplier = '0;
				mul_nbits  = cce_pkg::ALPHA_BITS;
				mul_bias   = 16'h0000;
			end
		endcase
	end

	// Saturating updates of the totals.
	always_comb begin
		f_neg    = f_q[cce_pkg::F_W-1];
		chg      = mul_prod[cce_pkg::CHG_W-1:0];
		chg_abs  = f_neg ? ({cce_pkg::CHG_W{1'b0}} - chg) : chg;
		chg_mag  = chg_abs[cce_pkg::MAG_W-1:0];
		net_sum  = $signed({{(SUM_W-ACC_WIDTH){net_q[ACC_WIDTH-1]}}, net_q}
		           + {{(SUM_W-cce_pkg::CHG_W){chg[cce_pkg::CHG_W-1]}}, chg});
		dir_base = {{(SUM_W-ACC_WIDTH+1){1'b0}}, (f_neg ? in_q : out_q)};
		dir_sum  = dir_base + {{(SUM_W-cce_pkg::MAG_W){1'b0}}, chg_mag};
		dir_next = (dir_sum > $unsigned(SAT_MAX)) ? SAT_MAX[ACC_WIDTH-2:0]
		                                          : dir_sum[ACC_WIDTH-2:0];
		em       = mul_prod[16 +: cce_pkg::EM_W];
		// The energy step is negative when load voltage and current differ in sign.
		em_delta = (load_neg_q ^ f_neg) ? ({cce_pkg::DLT_W{1'b0}} - {1'b0, em})
		                                : {1'b0, em};
		nrg_sum  = $signed({{(SUM_W-ACC_WIDTH){nrg_q[ACC_WIDTH-1]}}, nrg_q}
		           + {{(SUM_W-cce_pkg::DLT_W){em_delta[cce_pkg::DLT_W-1]}}, em_delta});
	end

	// Result formatting from the current filter value.
	always_comb begin
		f_rnd   = f_q + $signed({{(cce_pkg::F_W-16){1'b0}}, cce_pkg::ROUND_HALF});
		fc_full = f_rnd[cce_pkg::F_W-1:16];
		if (fc_full > $signed((cce_pkg::F_W-16)'(32767))) begin
			fc = 16'sh7FFF;
		end else if (fc_full < $signed(-(cce_pkg::F_W-16)'(32768))) begin
			fc = 16'sh8000;
		end else begin
			fc = fc_full[15:0];
		end
		f_mag = f_neg ? ({cce_pkg::F_W{1'b0}} - f_q) : f_q;
		if (f_mag < {{(cce_pkg::F_W-31){1'b0}}, idle_band_q, 16'h0000}) begin
			ps = cce_pkg::PS_IDLE;
		end else if (f_neg) begin
			ps = cce_pkg::PS_CHARGE;
		end else begin
			ps = cce_pkg::PS_DISCHARGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_q      <= '0;
			primed_q <= 1'b0;
			net_q    <= '0;
			out_q    <= '0;
			in_q     <= '0;
			nrg_q    <= '0;
		end else begin
			// The first sample after reset primes the filter with its own value.
			if (ctrl.load_in && !primed_q) begin
				f_q      <= {{2{in_cur_kept[15]}}, in_cur_kept, 16'h0000};
				primed_q <= 1'b1;
			end else if (ctrl.ema_upd) begin
				f_q <= f_q + $signed(mul_prod[16 +: cce_pkg::F_W]);
			end
			if (ctrl.chg_acc) begin
				if (net_sum > SAT_MAX) begin
					net_q <= SAT_MAX[ACC_WIDTH-1:0];
				end else if (net_sum < SAT_MIN) begin
					net_q <= SAT_MIN[ACC_WIDTH-1:0];
				end else begin
					net_q <= net_sum[ACC_WIDTH-1:0];
				end
				if (f_neg) begin
					in_q <= dir_next;
				end else begin
					out_q <= dir_next;
				end
			end
			if (ctrl.nrg_acc) begin
				if (nrg_sum > SAT_MAX) begin
					nrg_q <= SAT_MAX[ACC_WIDTH-1:0];
				end else if (nrg_sum < SAT_MIN) begin
					nrg_q <= SAT_MIN[ACC_WIDTH-1:0];
				end else begin
					nrg_q <= nrg_sum[ACC_WIDTH-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in) begin
			cur_q      <= in_cur_kept;
			el_q       <= s_tdata[15:0];
			load_q     <= in_load;
			load_neg_q <= in_load[cce_pkg::LOAD_W-1];
			load_mag_q <= in_load[cce_pkg::LOAD_W-1] ? in_load_neg[cce_pkg::LMAG_W-1:0]
			                                         : in_load[cce_pkg::LMAG_W-1:0];
		end
		if (ctrl.chg_acc) begin
			chg_mag_q <= chg_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.publish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.publish) begin
			fc_oq   <= fc;
			load_oq <= load_q;
			net_oq  <= net_q;
			out_oq  <= out_q;
			in_oq   <= in_q;
			nrg_oq  <= nrg_q;
			ps_oq   <= ps;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, ps_oq, 64'(nrg_oq), 63'(in_oq), 63'(out_oq), 64'(net_oq),
	                   load_oq, fc_oq};

	a_pub_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.publish |=> m_tvalid)
		else $error("published result not presented");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("block ready again right after a request");

	a_no_pub_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.publish |-> !m_tvalid || m_tready)
		else $error("result register overwritten before it was taken");

endmodule
